// ===== src/adc_average_voltage_bcd_display_unit_macros.svh =====
// Assertion macros for the averaged voltage display block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ADC_AVERAGE_VOLTAGE_BCD_DISPLAY_UNIT_MACROS_SVH
`define ADC_AVERAGE_VOLTAGE_BCD_DISPLAY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define AAVBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define AAVBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define AAVBD_ASSERT(lbl, prop, msg)
`define AAVBD_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== src/aavbd_pkg.sv =====
// Shared types, constants and the segment table of the averaged voltage display.
// No dependencies.
package aavbd_pkg;

  localparam int unsigned SAMPLES = 8;
  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 13;
  localparam int unsigned CntW    = 3;
  localparam int unsigned BcdW    = 6;

  localparam logic [1:0] SEL_LOW  = 2'd1;
  localparam logic [1:0] SEL_HIGH = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_kind_e;

  typedef struct packed {
    logic               action;
    logic [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [6:0]      segments;
    logic [1:0]      digit_select;
    logic [BcdW-1:0] shown_value;
  } out_item_t;

  typedef struct packed {
    op_kind_e           kind;
    logic [SampleW-1:0] sample;
  } op_t;

  function automatic logic [6:0] seg_of(input logic [3:0] nib);
    logic [6:0] s;
    case (nib)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

endpackage

// ===== src/aavbd_front.sv =====
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on aavbd_pkg.
module aavbd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  aavbd_pkg::in_item_t in_item_i,
  input  logic                take_i,
  output logic                valid_o,
  output aavbd_pkg::op_t      op_o
);

  aavbd_pkg::op_t mem_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_q, rd_q;
  logic           do_push, do_pop;
  aavbd_pkg::op_t op_in;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push && !full;
  assign do_pop  = take_i && valid_o;

  always_comb begin
    op_in.kind   = in_item_i.action ? aavbd_pkg::OP_TICK : aavbd_pkg::OP_SAMPLE;
    op_in.sample = in_item_i.sample;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_in;
  end

endmodule

// ===== src/aavbd_back.sv =====
// Back end: accumulates samples, converts the average to packed BCD tenths of
// a volt, and turns ticks into segment beats in a two-entry result queue.
// Depends on aavbd_pkg.
module aavbd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  aavbd_pkg::op_t       op_i,
  output logic                 take_o,
  output logic                 empty,
  input  logic                 pop,
  output aavbd_pkg::out_item_t out_item_o
);

  logic [aavbd_pkg::SumW-1:0] sum_q, sum_d;
  logic [aavbd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [aavbd_pkg::BcdW-1:0] held_q, held_d;
  logic                       turn_q;

  aavbd_pkg::out_item_t omem_q [2];
  logic [1:0]           ocnt_q, ocnt_d;
  logic                 owr_q, ord_q;
  logic                 opush, opop, is_tick;

  logic [aavbd_pkg::CntW:0]      n;
  logic [aavbd_pkg::SumW-1:0]    sum_nxt;
  logic [aavbd_pkg::SampleW-1:0] avg;
  logic [15:0]                   x, y;
  logic [5:0]                    volts;
  logic [1:0]                    tens;
  logic [3:0]                    ones;
  logic [3:0]                    nib;
  aavbd_pkg::out_item_t          res;

  assign is_tick = (op_i.kind == aavbd_pkg::OP_TICK);
  assign take_o  = valid_i && (!is_tick || ocnt_q != 2'd2);
  assign opush   = take_o && is_tick;
  assign empty   = (ocnt_q == 2'd0);
  assign opop    = pop && !empty;
  assign out_item_o = omem_q[ord_q];

  always_comb begin
    n       = {1'b0, cnt_q} + 1'b1;
    sum_nxt = sum_q + aavbd_pkg::SumW'(op_i.sample);
    avg     = aavbd_pkg::SampleW'(sum_nxt / aavbd_pkg::SAMPLES);
    // avg*33 + 511, then /1023 via x + x/1024 + 1 >> 10 (exact for this range)
    x       = {1'b0, avg, 5'b0} + 16'(avg) + 16'd511;
    y       = x + 16'(x[15:10]) + 16'd1;
    volts   = y[15:10];
    if (volts >= 6'd30) begin
      tens = 2'd3;
      ones = 4'(volts - 6'd30);
    end else if (volts >= 6'd20) begin
      tens = 2'd2;
      ones = 4'(volts - 6'd20);
    end else if (volts >= 6'd10) begin
      tens = 2'd1;
      ones = 4'(volts - 6'd10);
    end else begin
      tens = 2'd0;
      ones = volts[3:0];
    end

    sum_d  = sum_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    if (take_o && !is_tick) begin
      if (n >= (aavbd_pkg::CntW+1)'(aavbd_pkg::SAMPLES)) begin
        sum_d  = '0;
        cnt_d  = '0;
        held_d = {tens, ones};
      end else begin
        sum_d = sum_nxt;
        cnt_d = n[aavbd_pkg::CntW-1:0];
      end
    end

    nib              = turn_q ? {2'b00, held_q[5:4]} : held_q[3:0];
    res.segments     = aavbd_pkg::seg_of(nib);
    res.digit_select = turn_q ? aavbd_pkg::SEL_HIGH : aavbd_pkg::SEL_LOW;
    res.shown_value  = held_q;

    ocnt_d = ocnt_q;
    if (opush && !opop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (opop && !opush) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
      turn_q <= 1'b0;
      ocnt_q <= 2'd0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      ocnt_q <= ocnt_d;
      if (opush) begin
        turn_q <= ~turn_q;
        owr_q  <= ~owr_q;
      end
      if (opop) ord_q <= ~ord_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) omem_q[owr_q] <= res;
  end

endmodule

// ===== src/adc_average_voltage_bcd_display_unit.sv =====
// Averaged converter reading on a two-digit multiplexed seven-segment display.
// Input queue: drive in_item_i and raise push while full is low; one beat per
// cycle. action 0 carries a 10-bit sample, action 1 is a refresh tick.
// Every SAMPLES samples the average is scaled to tenths of a volt and held as
// packed BCD. Samples give no result beat.
// Result queue: each tick yields one beat (segments, digit_select, held BCD)
// visible while empty is low; take it with pop. Low digit first, then alternate.
// A tick passes the input queue and then the result queue to the result ports.
// The back end takes one item per cycle unless a tick waits on a full queue.
// A two-entry queue sits on each side; when the receiver stalls the result
// queue fills, the back end holds ticks, the input queue fills and full rises.
// The input queue drains in order, so a tick stalled at its head behind a full
// result queue blocks later samples too.
// Reset (rst_ni low, async) empties both queues, clears the accumulator, count
// and held value, and makes the next tick drive the low digit.
// Depends on aavbd_pkg, aavbd_front, aavbd_back and the macros header.
`include "adc_average_voltage_bcd_display_unit_macros.svh"

module adc_average_voltage_bcd_display_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  aavbd_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output aavbd_pkg::out_item_t out_item_o
);

  logic           link_valid;
  logic           link_take;
  aavbd_pkg::op_t op;

  aavbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .take_i    (link_take),
    .valid_o   (link_valid),
    .op_o      (op)
  );

  aavbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (link_valid),
    .op_i       (op),
    .take_o     (link_take),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  `AAVBD_ASSERT_IMP(a_take_valid, link_take, link_valid, "back end took from empty front queue")
  `AAVBD_ASSERT_IMP(a_sel_legal, !empty, (out_item_o.digit_select == aavbd_pkg::SEL_LOW || out_item_o.digit_select == aavbd_pkg::SEL_HIGH), "bad digit select")
  `AAVBD_ASSERT_IMP(a_bcd_legal, !empty, (out_item_o.shown_value[3:0] <= 4'd9), "held value is not BCD")
  `AAVBD_ASSERT_IMP(a_full_cause, $rose(full), $past(push), "full rose without a push")

endmodule
